/* hdl/afb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afb_pkg: shared codes and widths for the lockout and backoff gate
// command, answer and verdict codes, register indexes and field widths
// ----------------------------------------------------------------------------
package afb_pkg;

    localparam int CountW   = 8;
    localparam int DelayW   = 32;
    localparam int CodeW    = 2;
    localparam int CfgIdxW  = 2;
    localparam int InDataW  = 8;
    localparam int OutDataW = 48;

    // commands
    localparam logic [CodeW-1:0] CMD_OBSERVE = 2'd0;
    localparam logic [CodeW-1:0] CMD_RESTORE = 2'd1;
    localparam logic [CodeW-1:0] CMD_RESET   = 2'd2;

    // observed answers
    localparam logic [CodeW-1:0] ANS_ACCEPTED  = 2'd0;
    localparam logic [CodeW-1:0] ANS_REJECTED  = 2'd1;
    localparam logic [CodeW-1:0] ANS_FORBIDDEN = 2'd2;

    // verdicts
    localparam logic [CodeW-1:0] VERDICT_NONE    = 2'd0;
    localparam logic [CodeW-1:0] VERDICT_REVOKED = 2'd1;
    localparam logic [CodeW-1:0] VERDICT_SCOPE   = 2'd2;

    // configuration register indexes
    localparam logic [CfgIdxW-1:0] REG_MAX_REJECTIONS = 2'd0;
    localparam logic [CfgIdxW-1:0] REG_BASE_BACKOFF   = 2'd1;
    localparam logic [CfgIdxW-1:0] REG_MAX_BACKOFF    = 2'd2;

    localparam logic [CountW-1:0] COUNT_MAX = '1;

endpackage

/* hdl/afb_backoff.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afb_backoff: capped exponential backoff
// base doubled once per rejection past the first, clipped at the ceiling
// ----------------------------------------------------------------------------
module afb_backoff
(
    input  logic [afb_pkg::CountW-1:0] count,
    input  logic [afb_pkg::DelayW-1:0] base_ms,
    input  logic [afb_pkg::DelayW-1:0] cap_ms,
    output logic [afb_pkg::DelayW-1:0] delay_ms
);

    localparam int ShiftW = $clog2(afb_pkg::DelayW);

    logic [afb_pkg::CountW-1:0]   shift_amt;
    logic                         shift_big;
    logic [2*afb_pkg::DelayW-1:0] shifted;
    logic                         over_cap;

    assign shift_amt = count - afb_pkg::CountW'(1);
    // a shift of a full word or more always passes any ceiling unless base is zero
    assign shift_big = (shift_amt[afb_pkg::CountW-1:ShiftW] != '0);
    assign shifted   = {{afb_pkg::DelayW{1'b0}}, base_ms} << shift_amt[ShiftW-1:0];

    always_comb
    begin
        if (shift_big)
        begin
            over_cap = (base_ms != '0);
        end
        else
        begin
            over_cap = (shifted >= {{afb_pkg::DelayW{1'b0}}, cap_ms});
        end
    end

    always_comb
    begin
        if (count == '0)
        begin
            delay_ms = '0;
        end
        else if (over_cap)
        begin
            delay_ms = cap_ms;
        end
        else
        begin
            delay_ms = shifted[afb_pkg::DelayW-1:0];
        end
    end

endmodule

/* hdl/auth_failure_lockout_backoff.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// auth_failure_lockout_backoff: rejection counter with lockout and backoff
// counts consecutive credential rejections, latches a lockout verdict and
// reports a capped exponential retry delay for every request
// ----------------------------------------------------------------------------
// result: registered, valid in the cycle after request acceptance
// throughput: one request per cycle unless a stalled result blocks it; the gate state
//   and result register load at the accepting edge; the next request sees the new state
// reset: asynchronous, clears count, pending and latched verdicts, restores
//   the register defaults (budget 3, base 1000 ms, ceiling 60000 ms)
// ----------------------------------------------------------------------------
module auth_failure_lockout_backoff
(
    input  logic                           clk,
    input  logic                           rst_n,

    // configuration write port
    input  logic                           cfg_we,
    input  logic [afb_pkg::CfgIdxW-1:0]    cfg_index,
    input  logic [afb_pkg::DelayW-1:0]     cfg_data,

    // request stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [afb_pkg::InDataW-1:0]    s_tdata,   // answer [1:0], restore_verdict [3:2]
    input  logic [afb_pkg::CodeW-1:0]      s_tuser,   // command [1:0]

    // result stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [afb_pkg::OutDataW-1:0]   m_tdata    // verdict [1:0], is_blocked [2],
                                                      // rejection_count [10:3],
                                                      // backoff_ms [42:11]
);

    // configuration registers
    logic [afb_pkg::CountW-1:0] max_rej_reg;
    logic [afb_pkg::DelayW-1:0] base_reg;
    logic [afb_pkg::DelayW-1:0] cap_reg;

    // gate state
    logic [afb_pkg::CountW-1:0] count_reg,   count_next;
    logic [afb_pkg::CodeW-1:0]  pending_reg, pending_next;
    logic [afb_pkg::CodeW-1:0]  latched_reg, latched_next;

    // result register
    logic                         out_valid_reg;
    logic [afb_pkg::OutDataW-1:0] out_data_reg, out_data_next;

    logic                         accept;
    logic [afb_pkg::CodeW-1:0]    answer;
    logic [afb_pkg::CodeW-1:0]    restore_verdict;
    logic [afb_pkg::CountW-1:0]   count_inc;
    logic [afb_pkg::DelayW-1:0]   delay_ms;

    assign answer          = s_tdata[1:0];
    assign restore_verdict = s_tdata[3:2];

    // the result register frees itself in the same cycle it is taken
    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // saturating increment
    assign count_inc = (count_reg == afb_pkg::COUNT_MAX) ? count_reg
                                                         : count_reg + afb_pkg::CountW'(1);

    // next gate state for the request on the input
    always_comb
    begin
        count_next   = count_reg;
        pending_next = pending_reg;
        latched_next = latched_reg;
        case (s_tuser)
            afb_pkg::CMD_OBSERVE:
            begin
                case (answer)
                    afb_pkg::ANS_ACCEPTED:
                    begin
                        // latched verdict survives a success
                        count_next   = '0;
                        pending_next = afb_pkg::VERDICT_NONE;
                    end
                    afb_pkg::ANS_REJECTED,
                    afb_pkg::ANS_FORBIDDEN:
                    begin
                        pending_next = (answer == afb_pkg::ANS_REJECTED)
                                       ? afb_pkg::VERDICT_REVOKED
                                       : afb_pkg::VERDICT_SCOPE;
                        // once blocked the count is frozen
                        if (latched_reg == afb_pkg::VERDICT_NONE)
                        begin
                            count_next = count_inc;
                            if (count_inc >= max_rej_reg)
                            begin
                                latched_next = pending_next;
                            end
                        end
                    end
                    default:
                    begin
                        // silent answer leaves the gate alone
                    end
                endcase
            end
            afb_pkg::CMD_RESTORE:
            begin
                if (restore_verdict == afb_pkg::VERDICT_REVOKED ||
                    restore_verdict == afb_pkg::VERDICT_SCOPE)
                begin
                    latched_next = restore_verdict;
                    pending_next = restore_verdict;
                    count_next   = max_rej_reg;
                end
                else
                begin
                    // none or unknown verdict clears the gate
                    count_next   = '0;
                    pending_next = afb_pkg::VERDICT_NONE;
                    latched_next = afb_pkg::VERDICT_NONE;
                end
            end
            afb_pkg::CMD_RESET:
            begin
                count_next   = '0;
                pending_next = afb_pkg::VERDICT_NONE;
                latched_next = afb_pkg::VERDICT_NONE;
            end
            default:
            begin
                // unused command reports the current state
            end
        endcase
    end

    // backoff from the updated count
    afb_backoff u_backoff
    (
        .count    (count_next),
        .base_ms  (base_reg),
        .cap_ms   (cap_reg),
        .delay_ms (delay_ms)
    );

    // pack the result, zero pad to whole bytes
    assign out_data_next = {5'b0, delay_ms, count_next,
                            (latched_next != afb_pkg::VERDICT_NONE), latched_next};

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_rej_reg <= afb_pkg::CountW'(3);
            base_reg    <= afb_pkg::DelayW'(1000);
            cap_reg     <= afb_pkg::DelayW'(60000);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                afb_pkg::REG_MAX_REJECTIONS: max_rej_reg <= cfg_data[afb_pkg::CountW-1:0];
                afb_pkg::REG_BASE_BACKOFF:   base_reg    <= cfg_data;
                afb_pkg::REG_MAX_BACKOFF:    cap_reg     <= cfg_data;
                default:
                begin
                    // index beyond the register list is ignored
                end
            endcase
        end
    end

    // gate state and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            pending_reg   <= afb_pkg::VERDICT_NONE;
            latched_reg   <= afb_pkg::VERDICT_NONE;
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            count_reg     <= count_next;
            pending_reg   <= pending_next;
            latched_reg   <= latched_next;
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

/* hdl/afb_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afb_checker: port-level checks for the lockout and backoff gate
// watches the request and result streams and the result fields over time
// ----------------------------------------------------------------------------
module afb_checker
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    input  logic                         s_tready,
    input  logic [afb_pkg::CodeW-1:0]    s_tuser,
    input  logic                         m_tvalid,
    input  logic                         m_tready,
    input  logic [afb_pkg::OutDataW-1:0] m_tdata
);

    // blocked flag follows the verdict
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[2] == (m_tdata[1:0] != afb_pkg::VERDICT_NONE)))
    else $error("blocked flag disagrees with verdict");

    // no backoff without a rejection count
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[10:3] == '0) |-> (m_tdata[42:11] == '0))
    else $error("backoff reported with zero count");

    // a reset request yields a cleared result on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tuser == afb_pkg::CMD_RESET)
        |=> (m_tvalid && m_tdata[10:0] == '0))
    else $error("reset request did not clear the gate");

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result changed");

endmodule

bind auth_failure_lockout_backoff afb_checker u_afb_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

/* sim/tb_auth_failure_lockout_backoff.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_auth_failure_lockout_backoff: self-checking bench for the lockout gate
// drives command requests and configuration writes, tracks the gate state in a
// shadow copy, and compares every result field by field in arrival order
// ----------------------------------------------------------------------------
module tb_auth_failure_lockout_backoff;

    import afb_pkg::*;

    // codes the package leaves unnamed
    localparam logic [CodeW-1:0] CMD_UNUSED      = 2'd3;
    localparam logic [CodeW-1:0] ANS_SILENT      = 2'd3;
    localparam logic [CodeW-1:0] VERDICT_UNKNOWN = 2'd3;

    localparam logic [DelayW-1:0] DELAY_ALL_ONES = '1;

    localparam int WATCHDOG_LIMIT = 2000;  // cycles without any handshake
    localparam int LONG_HOLD      = 300;   // receiver hold-off under pressure
    localparam int SETTLE_CYCLES  = 3;     // settling margin after the last owed result
    localparam int PHASE_REQUESTS = 140;

    // one result as the block reports it
    typedef struct packed {
        logic [CodeW-1:0]  verdict;
        logic              blocked;
        logic [CountW-1:0] fails;
        logic [DelayW-1:0] backoff_ms;
    } gate_status_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                cfg_we = 1'b0;
    logic [CfgIdxW-1:0]  cfg_index = '0;
    logic [DelayW-1:0]   cfg_data = '0;

    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [InDataW-1:0]  s_tdata = '0;    // answer [1:0], restore_verdict [3:2]
    logic [CodeW-1:0]    s_tuser = '0;    // command [1:0]

    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [OutDataW-1:0] m_tdata;         // verdict [1:0], is_blocked [2],
                                          // rejection_count [10:3], backoff_ms [42:11]

    // shadow of the gate registers, starting from their reset values
    logic [CountW-1:0] cfg_budget  = 8'd3;
    logic [DelayW-1:0] cfg_base_ms = 32'd1000;
    logic [DelayW-1:0] cfg_cap_ms  = 32'd60000;

    // shadow of the gate state
    logic [CountW-1:0] gate_fails   = '0;
    logic [CodeW-1:0]  gate_pending = VERDICT_NONE;
    logic [CodeW-1:0]  gate_latched = VERDICT_NONE;

    // status words still owed by the block, oldest first
    gate_status_t outstanding_status[$];

    logic no_gaps = 1'b0;       // both sides run back to back while set
    logic hold_results = 1'b0;  // asks the receiver for one long hold-off

    int n_requests = 0;
    int n_results  = 0;
    int n_errors   = 0;
    int n_settings = 0;
    int n_lockouts = 0;
    int peak_fails = 0;

    auth_failure_lockout_backoff dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // gate prediction
    // ------------------------------------------------------------------------

    // base doubled once per rejection past the first, stopping at the ceiling
    function automatic logic [DelayW-1:0] backoff_for(input logic [CountW-1:0] fails);
        logic [63:0] delay;
        logic [63:0] ceiling;
        int step;
        if (fails == 0)
        begin
            return '0;
        end
        delay = {32'd0, cfg_base_ms};
        ceiling = {32'd0, cfg_cap_ms};
        for (step = 1; step < int'(fails); step++)
        begin
            if (delay >= ceiling)
            begin
                break;
            end
            delay = delay + delay;
        end
        return (delay < ceiling) ? delay[DelayW-1:0] : cfg_cap_ms;
    endfunction

    // applies one request to the shadow state and returns the status it yields
    function automatic gate_status_t advance_gate(input logic [CodeW-1:0] cmd, ans, rv);
        gate_status_t st;
        case (cmd)
            CMD_OBSERVE:
            begin
                if (ans == ANS_ACCEPTED)
                begin
                    // a good login clears the run but not a latched verdict
                    gate_fails = '0;
                    gate_pending = VERDICT_NONE;
                end
                else if (ans == ANS_REJECTED || ans == ANS_FORBIDDEN)
                begin
                    gate_pending = (ans == ANS_REJECTED) ? VERDICT_REVOKED : VERDICT_SCOPE;
                    // once blocked only the pending verdict follows the answers
                    if (gate_latched == VERDICT_NONE)
                    begin
                        if (gate_fails != COUNT_MAX)
                        begin
                            gate_fails = gate_fails + 1'b1;
                        end
                        if (gate_fails >= cfg_budget)
                        begin
                            gate_latched = gate_pending;
                            n_lockouts++;
                        end
                    end
                end
            end
            CMD_RESTORE:
            begin
                if (rv == VERDICT_REVOKED || rv == VERDICT_SCOPE)
                begin
                    gate_latched = rv;
                    gate_pending = rv;
                    gate_fails = cfg_budget;
                end
                else
                begin
                    // none or an unknown code restores a clean gate
                    gate_fails = '0;
                    gate_pending = VERDICT_NONE;
                    gate_latched = VERDICT_NONE;
                end
            end
            CMD_RESET:
            begin
                gate_fails = '0;
                gate_pending = VERDICT_NONE;
                gate_latched = VERDICT_NONE;
            end
            default:
            begin
                // unused command leaves everything as it is
            end
        endcase
        if (int'(gate_fails) > peak_fails)
        begin
            peak_fails = int'(gate_fails);
        end
        st.verdict = gate_latched;
        st.blocked = (gate_latched != VERDICT_NONE);
        st.fails = gate_fails;
        st.backoff_ms = backoff_for(gate_fails);
        return st;
    endfunction

    // ------------------------------------------------------------------------
    // shared stimulus helpers
    // ------------------------------------------------------------------------

    // mostly no gap, some short ones, now and then a long one
    function automatic int pick_gap();
        int roll;
        if (no_gaps)
        begin
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 65)
        begin
            return 0;
        end
        if (roll < 93)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [CodeW-1:0] rand_code();
        return CodeW'($urandom_range(0, 3));
    endfunction

    // entered and left just after a falling edge; valid stays high on return so
    // that the next request can follow without a bubble
    task automatic send_request(input logic [CodeW-1:0] cmd, ans, rv);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(InDataW - 2 * CodeW){1'b0}}, rv, ans};
        s_tuser  <= cmd;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        outstanding_status.push_back(advance_gate(cmd, ans, rv));
        n_requests++;
        @(negedge clk);
    endtask

    // closes a burst and waits for every owed status to come back
    task automatic finish_burst();
        s_tvalid <= 1'b0;
        while (outstanding_status.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // writes all three registers on consecutive edges; only called when idle
    task automatic configure(input logic [CountW-1:0] budget,
                             input logic [DelayW-1:0] base_ms,
                             input logic [DelayW-1:0] cap_ms);
        cfg_we    <= 1'b1;
        cfg_index <= REG_MAX_REJECTIONS;
        cfg_data  <= {{(DelayW - CountW){1'b0}}, budget};
        @(negedge clk);
        cfg_index <= REG_BASE_BACKOFF;
        cfg_data  <= base_ms;
        @(negedge clk);
        cfg_index <= REG_MAX_BACKOFF;
        cfg_data  <= cap_ms;
        @(negedge clk);
        cfg_we    <= 1'b0;
        cfg_budget  = budget;
        cfg_base_ms = base_ms;
        cfg_cap_ms  = cap_ms;
        n_settings++;
    endtask

    // one realistic slice of traffic: usually a run of failed logins
    task automatic send_episode(output int sent);
        int kind;
        int run_len;
        int i;
        logic [CodeW-1:0] failure;
        sent = 0;
        kind = $urandom_range(0, 99);
        if (kind < 70)
        begin
            run_len = $urandom_range(1, ((cfg_budget > 10) ? 10 : int'(cfg_budget)) + 2);
            for (i = 0; i < run_len; i++)
            begin
                failure = $urandom_range(0, 1) ? ANS_FORBIDDEN : ANS_REJECTED;
                send_request(CMD_OBSERVE, failure, rand_code());
                sent++;
            end
            if ($urandom_range(0, 9) < 7)
            begin
                send_request(CMD_OBSERVE, ANS_ACCEPTED, rand_code());
                sent++;
            end
        end
        else if (kind < 80)
        begin
            send_request(CMD_RESTORE, rand_code(), rand_code());
            sent++;
        end
        else if (kind < 86)
        begin
            send_request(CMD_RESET, rand_code(), rand_code());
            sent++;
        end
        else
        begin
            // noise: any command with any field contents
            send_request(rand_code(), rand_code(), rand_code());
            sent++;
        end
    endtask

    // ------------------------------------------------------------------------
    // test tasks
    // ------------------------------------------------------------------------

    // reset values of the registers, latching, and every command
    task automatic test_reset_defaults();
        send_request(CMD_OBSERVE, ANS_REJECTED, VERDICT_SCOPE);
        send_request(CMD_OBSERVE, ANS_FORBIDDEN, VERDICT_NONE);
        send_request(CMD_OBSERVE, ANS_REJECTED, VERDICT_UNKNOWN);   // latches revoked
        send_request(CMD_OBSERVE, ANS_FORBIDDEN, VERDICT_NONE);     // blocked: count holds
        send_request(CMD_OBSERVE, ANS_ACCEPTED, VERDICT_REVOKED);   // blocked: verdict stays
        send_request(CMD_OBSERVE, ANS_SILENT, VERDICT_SCOPE);
        send_request(CMD_UNUSED, ANS_REJECTED, VERDICT_UNKNOWN);
        send_request(CMD_RESTORE, ANS_REJECTED, VERDICT_SCOPE);     // answer ignored
        send_request(CMD_RESET, ANS_FORBIDDEN, VERDICT_REVOKED);
        send_request(CMD_RESTORE, ANS_ACCEPTED, VERDICT_REVOKED);
        send_request(CMD_RESTORE, ANS_SILENT, VERDICT_UNKNOWN);     // unknown code clears
        send_request(CMD_RESTORE, ANS_FORBIDDEN, VERDICT_REVOKED);
        send_request(CMD_RESTORE, ANS_REJECTED, VERDICT_NONE);
        finish_burst();
    endtask

    // register extremes: zero base and ceiling, widest values, zero budget
    task automatic test_register_extremes();
        configure(8'd1, '0, '0);
        send_request(CMD_OBSERVE, ANS_FORBIDDEN, VERDICT_NONE);
        send_request(CMD_RESET, ANS_SILENT, VERDICT_SCOPE);
        finish_burst();
        configure(COUNT_MAX, 32'd1, DELAY_ALL_ONES);
        send_request(CMD_RESTORE, ANS_ACCEPTED, VERDICT_SCOPE);     // count at 255
        send_request(CMD_OBSERVE, ANS_ACCEPTED, VERDICT_NONE);
        finish_burst();
        configure('0, DELAY_ALL_ONES, DELAY_ALL_ONES);
        send_request(CMD_OBSERVE, ANS_FORBIDDEN, VERDICT_NONE);     // zero budget latches at once
        send_request(CMD_RESTORE, ANS_REJECTED, VERDICT_REVOKED);   // count restored to zero
        send_request(CMD_RESET, ANS_ACCEPTED, VERDICT_NONE);
        finish_burst();
    endtask

    // a rejection run long enough to reach the top of the count
    task automatic test_count_ceiling();
        int i;
        configure(COUNT_MAX, 32'($urandom_range(1, 7)), DELAY_ALL_ONES);
        for (i = 0; i < 258; i++)
        begin
            send_request(CMD_OBSERVE, $urandom_range(0, 1) ? ANS_FORBIDDEN : ANS_REJECTED,
                         rand_code());
        end
        send_request(CMD_OBSERVE, ANS_ACCEPTED, rand_code());
        finish_burst();
    endtask

    // receiver holds off for a long stretch while requests keep coming
    task automatic test_backpressure();
        int sent;
        int total;
        configure(8'($urandom_range(2, 6)), 32'($urandom_range(1, 5000)),
                  32'($urandom_range(1000, 200000)));
        no_gaps = 1'b1;
        hold_results = 1'b1;
        while (hold_results)
        begin
            @(negedge clk);
        end
        total = 0;
        while (total < 60)
        begin
            send_episode(sent);
            total += sent;
        end
        finish_burst();
        no_gaps = 1'b0;
    endtask

    // random settings, each followed by a phase of random login traffic
    task automatic test_random_traffic();
        int phase;
        int sent;
        int total;
        logic [CountW-1:0] budget;
        logic [DelayW-1:0] base_ms;
        logic [DelayW-1:0] cap_ms;
        for (phase = 0; phase < 8; phase++)
        begin
            case ($urandom_range(0, 3))
                0:       budget = 8'd1;
                1:       budget = COUNT_MAX;
                2:       budget = 8'($urandom_range(2, 8));
                default: budget = 8'($urandom_range(1, 255));
            endcase
            case ($urandom_range(0, 4))
                0:       base_ms = '0;
                1:       base_ms = 32'd1;
                2:       base_ms = 32'($urandom_range(1, 5000));
                3:       base_ms = DELAY_ALL_ONES;
                default: base_ms = $urandom();
            endcase
            case ($urandom_range(0, 3))
                0:       cap_ms = '0;
                1:       cap_ms = 32'($urandom_range(1, 100000));
                2:       cap_ms = DELAY_ALL_ONES;
                default: cap_ms = $urandom();
            endcase
            configure(budget, base_ms, cap_ms);
            // every third phase runs with no idling on either side
            no_gaps = (phase % 3 == 2);
            total = 0;
            while (total < PHASE_REQUESTS)
            begin
                send_episode(sent);
                total += sent;
            end
            finish_burst();
        end
        no_gaps = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------------

    // random stalls, plus the long hold-off when a test asks for it
    initial
    begin : result_sink
        int stall;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_results)
            begin
                hold_results = 1'b0;
                stall = LONG_HOLD;
            end
            else if ($urandom_range(0, 3) == 0)
            begin
                stall = pick_gap();
            end
            else
            begin
                stall = 0;
            end
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready <= 1'b1;
        end
    end

    task automatic report_mismatch(input string what, input logic [DelayW-1:0] got,
                                   input logic [DelayW-1:0] want);
        $display("%0t: result %0d: %s is %0d, expected %0d", $time, n_results, what, got, want);
        n_errors++;
    endtask

    // compares each accepted result with the oldest owed status
    always @(posedge clk)
    begin : result_check
        gate_status_t got;
        gate_status_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            n_results++;
            got.verdict    = m_tdata[1:0];
            got.blocked    = m_tdata[2];
            got.fails      = m_tdata[10:3];
            got.backoff_ms = m_tdata[42:11];
            if (outstanding_status.size() == 0)
            begin
                report_mismatch("result with no request owed, verdict",
                                DelayW'(got.verdict), '0);
            end
            else
            begin
                want = outstanding_status.pop_front();
                if (got.verdict !== want.verdict)
                begin
                    report_mismatch("verdict", DelayW'(got.verdict), DelayW'(want.verdict));
                end
                if (got.blocked !== want.blocked)
                begin
                    report_mismatch("is_blocked", DelayW'(got.blocked), DelayW'(want.blocked));
                end
                if (got.fails !== want.fails)
                begin
                    report_mismatch("rejection_count", DelayW'(got.fails), DelayW'(want.fails));
                end
                if (got.backoff_ms !== want.backoff_ms)
                begin
                    report_mismatch("backoff_ms", got.backoff_ms, want.backoff_ms);
                end
            end
        end
    end

    // ends the run once neither side has moved for too long
    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
        end
        $display("%0t: no handshake for %0d cycles, %0d results still owed",
                 $time, WATCHDOG_LIMIT, outstanding_status.size());
        $display("*** FAILED ***");
        $finish;
    end

    // ------------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------------

    initial
    begin
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_defaults();
        test_register_extremes();
        test_count_ceiling();
        test_backpressure();
        test_random_traffic();

        // catch any stray result after the last one owed
        repeat (SETTLE_CYCLES * 3) @(posedge clk);

        $display("covered %0d requests and %0d results over %0d register settings",
                 n_requests, n_results, n_settings);
        $display("highest rejection count %0d, %0d lockouts latched by rejection runs",
                 peak_fails, n_lockouts);
        if (n_errors == 0 && outstanding_status.size() == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("%0d mismatches, %0d results never arrived",
                     n_errors, outstanding_status.size());
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

/* files.f */
hdl/afb_pkg.sv
hdl/afb_backoff.sv
hdl/auth_failure_lockout_backoff.sv
hdl/afb_checker.sv
sim/tb_auth_failure_lockout_backoff.sv
